@@ hw/rtl/sclp_pkg.sv @@
`default_nettype none

package sclp_pkg;

  // Number of decimal values a command line may carry
  localparam int unsigned VALUE_SLOTS = 2;
  localparam int unsigned SlotW = (VALUE_SLOTS > 1) ? $clog2(VALUE_SLOTS) : 1;
  // Second value comes from slot one when there is one
  localparam int unsigned SecondSlot = (VALUE_SLOTS >= 2) ? 1 : 0;

  // Token queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // Character codes
  localparam logic [7:0] ChEsc   = 8'd27;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowS  = 8'h73;
  localparam logic [7:0] ChLowL  = 8'h6c;
  localparam logic [7:0] ChLowR  = 8'h72;
  localparam logic [7:0] ChLowV  = 8'h76;
  localparam logic [7:0] ChCaseBit = 8'h20;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgBootIdx   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRebootIdx = 2'd1;
  localparam logic [15:0] BootCodeRst   = 16'd5511;
  localparam logic [15:0] RebootCodeRst = 16'd1033;

  typedef enum logic [3:0] {
    TK_STATUS,
    TK_LED,
    TK_RESET,
    TK_VALVE,
    TK_DIGIT,
    TK_SEP,
    TK_ESC,
    TK_BLANK,
    TK_OTHER
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] ch;
  } token_t;

  typedef enum logic [3:0] {
    ACT_STATUS     = 4'd0,
    ACT_BOOTLOADER = 4'd1,
    ACT_REBOOT     = 4'd2,
    ACT_LED        = 4'd3,
    ACT_VALVE      = 4'd4,
    ACT_BAD_CMD    = 4'd5,
    ACT_BAD_TARGET = 4'd6,
    ACT_BAD_CODE   = 4'd7,
    ACT_BAD_VALVE  = 4'd8
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [2:0]  led_mask;
    logic        valve_select;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [7:0]  bad_char;
    logic [15:0] error_value;
  } result_t;

  typedef struct packed {
    logic [15:0] boot_code;
    logic [15:0] reboot_code;
  } codes_t;

endpackage

`default_nettype wire

@@ hw/rtl/sclp_front.sv @@
`default_nettype none

module sclp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      rx_char_i,
  output logic                 tok_valid_o,
  output sclp_pkg::token_t     tok_o,
  input  wire logic            tok_pop_i
);
  import sclp_pkg::*;

  token_t             q_mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               push, pop;
  token_t             tok_new;

  // Classify the incoming byte
  always_comb begin
    tok_new.ch = rx_char_i;
    if ((rx_char_i | ChCaseBit) == ChLowS) begin
      tok_new.kind = TK_STATUS;
    end else if ((rx_char_i | ChCaseBit) == ChLowL) begin
      tok_new.kind = TK_LED;
    end else if ((rx_char_i | ChCaseBit) == ChLowR) begin
      tok_new.kind = TK_RESET;
    end else if ((rx_char_i | ChCaseBit) == ChLowV) begin
      tok_new.kind = TK_VALVE;
    end else if (rx_char_i >= ChZero && rx_char_i <= ChNine) begin
      tok_new.kind = TK_DIGIT;
    end else if (rx_char_i == ChComma || rx_char_i == ChColon) begin
      tok_new.kind = TK_SEP;
    end else if (rx_char_i == ChEsc) begin
      tok_new.kind = TK_ESC;
    end else if (rx_char_i <= ChSpace) begin
      tok_new.kind = TK_BLANK;
    end else begin
      tok_new.kind = TK_OTHER;
    end
  end

  assign in_stall_o  = (cnt_q == QCntW'(QDepth));
  assign push        = in_valid_i & ~in_stall_o;
  assign tok_valid_o = (cnt_q != '0);
  assign pop         = tok_valid_o & tok_pop_i;
  assign tok_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= tok_new;
    end
  end

`ifndef SYNTHESIS
  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_o && !tok_pop_i |=> tok_valid_o && $stable(tok_o))
    else $error("queue head changed while not popped");
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> tok_valid_o)
    else $error("input stalled with an empty queue");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sclp_back.sv @@
`default_nettype none

module sclp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tok_valid_i,
  input  wire sclp_pkg::token_t tok_i,
  output logic                  tok_pop_o,
  input  wire sclp_pkg::codes_t codes_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output sclp_pkg::result_t     res_o
);
  import sclp_pkg::*;

  localparam logic [1:0] PH_COMMAND = 2'd0;
  localparam logic [1:0] PH_TARGET  = 2'd1;
  localparam logic [1:0] PH_NEXT    = 2'd2;
  localparam logic [1:0] PH_VALUE   = 2'd3;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_RESET = 3'd2;
  localparam logic [2:0] CMD_VALVE = 3'd3;
  localparam logic [2:0] CMD_LED   = 3'd4;

  logic [1:0]       phase_q, phase_d;
  logic [2:0]       cmd_q, cmd_d;
  logic [3:0]       target_q, target_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [15:0]      store_q [VALUE_SLOTS];
  logic [15:0]      store_d [VALUE_SLOTS];
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res;
  logic             emit, fin, more, clr;
  logic [3:0]       digit;
  logic [15:0]      cur, v0, v1;

  assign tok_pop_o = tok_valid_i & (~out_valid_q | ~out_stall_i);
  assign digit     = tok_i.ch[3:0];
  assign cur       = store_q[slot_q];
  assign v0        = store_q[0];

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    target_d = target_q;
    slot_d   = slot_q;
    store_d  = store_q;
    res      = '0;
    emit     = 1'b0;
    fin      = 1'b0;
    more     = 1'b0;
    clr      = 1'b0;
    v1       = v0;

    unique case (phase_q)
      PH_COMMAND: begin
        case (tok_i.kind)
          TK_STATUS: begin
            emit = 1'b1;
            clr  = 1'b1;
          end
          TK_LED: begin
            cmd_d   = CMD_LED;
            phase_d = PH_TARGET;
          end
          TK_RESET: begin
            cmd_d   = CMD_RESET;
            phase_d = PH_NEXT;
          end
          TK_VALVE: begin
            cmd_d   = CMD_VALVE;
            phase_d = PH_TARGET;
          end
          TK_ESC, TK_BLANK: begin
          end
          default: begin
            emit         = 1'b1;
            clr          = 1'b1;
            res.action   = ACT_BAD_CMD;
            res.bad_char = tok_i.ch;
          end
        endcase
      end
      PH_TARGET: begin
        case (tok_i.kind)
          TK_ESC: clr = 1'b1;
          TK_DIGIT: begin
            target_d = digit;
            phase_d  = PH_NEXT;
          end
          TK_BLANK: begin
          end
          default: begin
            emit         = 1'b1;
            clr          = 1'b1;
            res.action   = ACT_BAD_TARGET;
            res.bad_char = tok_i.ch;
          end
        endcase
      end
      PH_NEXT: begin
        case (tok_i.kind)
          TK_ESC: clr = 1'b1;
          TK_DIGIT: begin
            store_d[slot_q] = {12'd0, digit};
            phase_d         = PH_VALUE;
          end
          default: begin
          end
        endcase
      end
      PH_VALUE: begin
        case (tok_i.kind)
          TK_ESC: clr = 1'b1;
          TK_DIGIT: begin
            // value * 10 + digit, wraps at 16 bits
            store_d[slot_q] = (cur << 3) + (cur << 1) + {12'd0, digit};
          end
          TK_SEP: begin
            if ((SlotW + 1)'(slot_q) + 1'b1 < (SlotW + 1)'(VALUE_SLOTS)) begin
              slot_d  = slot_q + 1'b1;
              phase_d = PH_NEXT;
            end else begin
              fin  = 1'b1;
              more = 1'b1;
            end
          end
          default: begin
            fin  = 1'b1;
            more = (slot_q != '0);
          end
        endcase
      end
    endcase

    // Decode the finished command
    if (fin) begin
      emit = 1'b1;
      clr  = 1'b1;
      if (more) begin
        v1 = store_q[SecondSlot];
      end
      case (cmd_q)
        CMD_RESET: begin
          res.first_value = v0;
          if (v0 == codes_i.boot_code) begin
            res.action = ACT_BOOTLOADER;
          end else if (v0 == codes_i.reboot_code) begin
            res.action = ACT_REBOOT;
          end else begin
            res.action      = ACT_BAD_CODE;
            res.error_value = v0;
          end
        end
        CMD_LED: begin
          res.action       = ACT_LED;
          res.led_mask     = target_q[2:0];
          res.first_value  = v0;
          res.second_value = v1;
        end
        CMD_VALVE: begin
          if (target_q <= 4'd1) begin
            res.action       = ACT_VALVE;
            res.valve_select = target_q[0];
            res.first_value  = v0;
          end else begin
            res.action      = ACT_BAD_VALVE;
            res.error_value = {12'd0, target_q};
          end
        end
        default: res.action = ACT_STATUS;
      endcase
    end

    if (clr) begin
      phase_d  = PH_COMMAND;
      cmd_d    = CMD_NONE;
      target_d = '0;
      slot_d   = '0;
      for (int i = 0; i < VALUE_SLOTS; i++) begin
        store_d[i] = '0;
      end
    end
  end

  assign out_valid_d = tok_pop_o ? emit : (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COMMAND;
      cmd_q       <= CMD_NONE;
      target_q    <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < VALUE_SLOTS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (tok_pop_o) begin
        phase_q  <= phase_d;
        cmd_q    <= cmd_d;
        target_q <= target_d;
        slot_q   <= slot_d;
        store_q  <= store_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o && emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_COMMAND |-> slot_q == '0 && target_q == '0 && cmd_q == CMD_NONE)
    else $error("parser idle with leftover command state");
  a_target_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TARGET |-> cmd_q == CMD_LED || cmd_q == CMD_VALVE)
    else $error("target phase without an LED or valve command");
  a_result_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tok_pop_o))
    else $error("result appeared without a consumed item");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/serial_command_line_parser_core.sv @@
`default_nettype none
// Channel  Handshake                  Payload
// -------  -------------------------  ------------------------------------------------
// in       in_valid_i / in_stall_o    rx_char_i
// out      out_valid_o / out_stall_i  action_o, led_mask_o, valve_select_o,
//                                     first_value_o, second_value_o, bad_char_o,
//                                     error_value_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; a result is registered after
// its item leaves the token queue (the item waits at the queue head while the parser
// steps it into the output register).
// The back-end parser does one state step per item; that step sets the rate.
// Reset is asynchronous, active low: parser idle, queue empty, codes back to 5511/1033.
// in_stall_o rises only when the two-entry token queue is full; a stall on out_stall_i
// holds a valid result and stops the parser, so the queue fills behind it.
module serial_command_line_parser_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // received characters
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [7:0]                  rx_char_i,
  // decoded command results
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [3:0]                       action_o,
  output logic [2:0]                       led_mask_o,
  output logic                             valve_select_o,
  output logic [15:0]                      first_value_o,
  output logic [15:0]                      second_value_o,
  output logic [7:0]                       bad_char_o,
  output logic [15:0]                      error_value_o,
  // register writes
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sclp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                 cfg_data_i
);
  import sclp_pkg::*;

  codes_t  codes_q;
  logic    tok_valid, tok_pop;
  token_t  tok;
  result_t res;

  // Register writes are always taken; unknown indexes drop silently
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.boot_code   <= BootCodeRst;
      codes_q.reboot_code <= RebootCodeRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBootIdx:   codes_q.boot_code   <= cfg_data_i;
        CfgRebootIdx: codes_q.reboot_code <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front: classify each byte and queue it as a token
  sclp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_char_i   (rx_char_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  // Back: run the command parser and register each result
  sclp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .codes_i     (codes_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign action_o       = res.action;
  assign led_mask_o     = res.led_mask;
  assign valve_select_o = res.valve_select;
  assign first_value_o  = res.first_value;
  assign second_value_o = res.second_value;
  assign bad_char_o     = res.bad_char;
  assign error_value_o  = res.error_value;

endmodule

`default_nettype wire

@@ bench/serial_command_line_parser_core_test.sv @@
module serial_command_line_parser_core_test;
  import sclp_pkg::*;

  // Longest deliberate receiver hold-off, in cycles; long enough to fill the block
  localparam int unsigned HoldCycles = 60;
  // Abort the run after this many cycles in which no item moves on any channel
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned NumRows = 38;

  // Parser phases and pending commands, kept in the bench's own terms
  typedef enum logic [1:0] {
    AWAIT_CMD,
    AWAIT_TARGET,
    AWAIT_VALUE,
    IN_VALUE
  } parse_phase_e;

  typedef enum logic [2:0] {
    PEND_NONE,
    PEND_STATUS,
    PEND_RESET,
    PEND_VALVE,
    PEND_LED
  } pend_cmd_e;

  // One line of the directed table: the character and, where it is obvious,
  // the result it must produce
  typedef struct {
    logic [7:0] ch;
    bit         has_want;
    result_t    want;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;

  // Character channel
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_char   = '0;
  logic        row_typed = 1'b0;
  result_t     row_want  = '0;
  logic        in_stall_o;

  // Result channel
  logic        out_stall = 1'b0;
  logic        out_valid_o;
  logic [3:0]  action_o;
  logic [2:0]  led_mask_o;
  logic        valve_select_o;
  logic [15:0] first_value_o;
  logic [15:0] second_value_o;
  logic [7:0]  bad_char_o;
  logic [15:0] error_value_o;

  // Register write channel
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgBootIdx;
  logic [15:0]        cfg_data  = '0;
  logic               cfg_ready_o;

  // Shadow of the block: codes plus parser state
  logic [15:0]  boot_code   = BootCodeRst;
  logic [15:0]  reboot_code = RebootCodeRst;
  parse_phase_e p_phase     = AWAIT_CMD;
  pend_cmd_e    p_cmd       = PEND_NONE;
  logic [3:0]   p_target    = '0;
  int unsigned  p_slot      = 0;
  logic [15:0]  p_vals [VALUE_SLOTS] = '{default: '0};

  result_t     pending_actions [$];
  stim_row_t   directed_rows [NumRows];
  int unsigned mismatches  = 0;
  int unsigned chars_sent  = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_gaps  = 1'b1;
  bit          rx_gaps  = 1'b1;
  bit          hold_req = 1'b0;

  serial_command_line_parser_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .rx_char_i      (rx_char),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .action_o       (action_o),
    .led_mask_o     (led_mask_o),
    .valve_select_o (valve_select_o),
    .first_value_o  (first_value_o),
    .second_value_o (second_value_o),
    .bad_char_o     (bad_char_o),
    .error_value_o  (error_value_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow
  // ---------------------------------------------------------------------------

  // Drop the command in progress and wait for a new command letter
  task automatic idle_parser();
    p_phase = AWAIT_CMD;
    p_cmd   = PEND_NONE;
    p_target = '0;
    p_slot  = 0;
    foreach (p_vals[i]) p_vals[i] = '0;
  endtask

  // Turn the finished command into its result; more says a second slot was opened
  task automatic close_command(input bit more, output result_t r);
    logic [15:0] v0;
    logic [15:0] v1;
    v0 = p_vals[0];
    v1 = more ? p_vals[SecondSlot] : v0;
    r = '0;
    case (p_cmd)
      PEND_RESET: begin
        r.first_value = v0;
        // Bootloader takes priority when both codes match
        if (v0 == boot_code) begin
          r.action = ACT_BOOTLOADER;
        end else if (v0 == reboot_code) begin
          r.action = ACT_REBOOT;
        end else begin
          r.action = ACT_BAD_CODE;
          r.error_value = v0;
        end
      end
      PEND_LED: begin
        // A zero target still answers with an empty colour mask
        r.action       = ACT_LED;
        r.led_mask     = p_target[2:0];
        r.first_value  = v0;
        r.second_value = v1;
      end
      PEND_VALVE: begin
        if (p_target <= 4'd1) begin
          r.action       = ACT_VALVE;
          r.valve_select = p_target[0];
          r.first_value  = v0;
        end else begin
          r.action      = ACT_BAD_VALVE;
          r.error_value = {12'd0, p_target};
        end
      end
      default: begin
        r.action = ACT_STATUS;
      end
    endcase
    idle_parser();
  endtask

  // Advance the shadow by one accepted character
  task automatic parse_char(input logic [7:0] c, output bit emit, output result_t r);
    logic [7:0] lc;
    bit         digit;
    lc    = c | ChCaseBit;
    digit = (c >= ChZero) && (c <= ChNine);
    emit  = 1'b0;
    r     = '0;
    case (p_phase)
      AWAIT_CMD: begin
        // Letters match in either case; blanks and ESC are dropped
        if (lc == ChLowS) begin
          p_cmd = PEND_STATUS;
          close_command(1'b0, r);
          emit = 1'b1;
        end else if (lc == ChLowL) begin
          p_cmd   = PEND_LED;
          p_phase = AWAIT_TARGET;
        end else if (lc == ChLowR) begin
          p_cmd   = PEND_RESET;
          p_phase = AWAIT_VALUE;
        end else if (lc == ChLowV) begin
          p_cmd   = PEND_VALVE;
          p_phase = AWAIT_TARGET;
        end else if (c > ChSpace) begin
          r.action   = ACT_BAD_CMD;
          r.bad_char = c;
          emit = 1'b1;
          idle_parser();
        end
      end
      AWAIT_TARGET: begin
        if (c == ChEsc) begin
          idle_parser();
        end else if (digit) begin
          p_target = 4'(c - ChZero);
          p_phase  = AWAIT_VALUE;
        end else if (c > ChSpace) begin
          r.action   = ACT_BAD_TARGET;
          r.bad_char = c;
          emit = 1'b1;
          idle_parser();
        end
      end
      AWAIT_VALUE: begin
        // Anything but a digit or ESC is skipped here
        if (c == ChEsc) begin
          idle_parser();
        end else if (digit) begin
          if (p_slot < VALUE_SLOTS) p_vals[p_slot] = {8'd0, c - ChZero};
          p_phase = IN_VALUE;
        end
      end
      default: begin
        if (c == ChEsc) begin
          idle_parser();
        end else if (digit) begin
          // Wraps modulo 2^16 by the width of the store
          if (p_slot < VALUE_SLOTS) begin
            p_vals[p_slot] = p_vals[p_slot] * 16'd10 + {8'd0, c - ChZero};
          end
        end else if (c == ChComma || c == ChColon) begin
          if (p_slot + 1 < VALUE_SLOTS) begin
            p_slot++;
            p_phase = AWAIT_VALUE;
          end else begin
            close_command(1'b1, r);
            emit = 1'b1;
          end
        end else begin
          close_command(p_slot > 0, r);
          emit = 1'b1;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Sample every channel at the clock edge; stimulus lands by NBA so the
  // values read here are the ones the block saw
  always @(posedge clk) begin
    result_t want;
    result_t parsed;
    bit      emitted;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (pending_actions.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item pending, action %0d", $time, action_o);
        end else begin
          want = pending_actions.pop_front();
          report("action",       16'(want.action),       16'(action_o));
          report("led_mask",     16'(want.led_mask),     16'(led_mask_o));
          report("valve_select", 16'(want.valve_select), 16'(valve_select_o));
          report("first_value",  want.first_value,       first_value_o);
          report("second_value", want.second_value,      second_value_o);
          report("bad_char",     16'(want.bad_char),     16'(bad_char_o));
          report("error_value",  want.error_value,       error_value_o);
        end
      end
      if (in_valid && !in_stall_o) begin
        // Always step the shadow; typed rows override what it predicts
        parse_char(rx_char, emitted, parsed);
        if (row_typed) begin
          pending_actions.push_back(row_want);
        end else if (emitted) begin
          pending_actions.push_back(parsed);
        end
      end
      if (cfg_valid && cfg_ready_o) begin
        if (cfg_index == CfgBootIdx) begin
          boot_code = cfg_data;
        end else if (cfg_index == CfgRebootIdx) begin
          reboot_code = cfg_data;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  function automatic stim_row_t plain(input logic [7:0] ch);
    stim_row_t r;
    r.ch       = ch;
    r.has_want = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic stim_row_t answer(input logic [7:0] ch, input action_e act,
                                       input logic sel, input logic [15:0] first,
                                       input logic [7:0] bad, input logic [15:0] err);
    stim_row_t r;
    r = plain(ch);
    r.has_want           = 1'b1;
    r.want.action        = act;
    r.want.valve_select  = sel;
    r.want.first_value   = first;
    r.want.bad_char      = bad;
    r.want.error_value   = err;
    return r;
  endfunction

  // Any byte that is not a digit, ESC or separator: skipped or a terminator
  function automatic logic [7:0] random_other();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= ChZero && c <= ChNine) || c == ChEsc || c == ChComma || c == ChColon);
    return c;
  endfunction

  function automatic logic [7:0] random_sep();
    return $urandom_range(0, 1) ? ChComma : ChColon;
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_char(input logic [7:0] c, input bit typed, input result_t want);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_char   <= c;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    chars_sent++;
  endtask

  // Value text: lean on the live codes and the 16-bit edges, sometimes overflow
  task automatic send_number();
    logic [7:0]  digits [$];
    int unsigned rest;
    case ($urandom_range(0, 7))
      0:       rest = boot_code;
      1:       rest = reboot_code;
      2:       rest = 0;
      3:       rest = 65535;
      4:       rest = $urandom_range(65536, 999999);
      5:       rest = $urandom_range(0, 99);
      default: rest = $urandom_range(0, 65535);
    endcase
    do begin
      digits.push_front(ChZero + 8'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    if ($urandom_range(0, 7) == 0) digits.push_front(ChZero);
    foreach (digits[i]) send_char(digits[i], 1'b0, '0);
  endtask

  // Mostly well-formed command lines with random content; some noise and
  // some lines broken off by ESC or a bad target
  task automatic send_random_command();
    int unsigned pick;
    int unsigned nvals;
    int unsigned k;
    logic [7:0]  letter;
    logic [7:0]  blank;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_char($urandom_range(0, 1) ? ChLowS : (ChLowS & ~ChCaseBit), 1'b0, '0);
    end else if (pick < 20) begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0, '0);
    end else begin
      if (pick < 45) begin
        letter = ChLowL;
      end else if (pick < 70) begin
        letter = ChLowV;
      end else begin
        letter = ChLowR;
      end
      if ($urandom_range(0, 1)) letter = letter & ~ChCaseBit;
      send_char(letter, 1'b0, '0);
      if ((letter | ChCaseBit) != ChLowR) begin
        while ($urandom_range(0, 4) == 0) begin
          blank = 8'($urandom_range(0, 32));
          send_char((blank == ChEsc) ? ChSpace : blank, 1'b0, '0);
        end
        k = $urandom_range(0, 15);
        if (k == 0) begin
          send_char(ChEsc, 1'b0, '0);
          return;
        end
        if (k == 1) begin
          send_char(random_other(), 1'b0, '0);
          return;
        end
        // Valve targets mostly 0 or 1, so pulses outnumber bad valves
        if ((letter | ChCaseBit) == ChLowV && $urandom_range(0, 2) != 0) begin
          send_char(ChZero + 8'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          send_char(ChZero + 8'($urandom_range(0, 9)), 1'b0, '0);
        end
      end
      nvals = $urandom_range(1, VALUE_SLOTS);
      for (int i = 0; i < nvals; i++) begin
        if ($urandom_range(0, 5) == 0) send_char(random_other(), 1'b0, '0);
        if ($urandom_range(0, 19) == 0) begin
          send_char(ChEsc, 1'b0, '0);
          return;
        end
        send_number();
        if (i + 1 < nvals) send_char(random_sep(), 1'b0, '0);
      end
      k = $urandom_range(0, 15);
      if (k == 0) begin
        send_char(ChEsc, 1'b0, '0);
      end else if (nvals == VALUE_SLOTS && k < 8) begin
        send_char(random_sep(), 1'b0, '0);
      end else begin
        send_char(random_other(), 1'b0, '0);
      end
    end
  endtask

  // Drop valid, wait for every pending result, then let any item still in
  // flight settle while the receiver is not stalling
  task automatic drain();
    int unsigned calm;
    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    calm = 0;
    while (calm < 4) begin
      @(posedge clk);
      if (!out_stall) calm++;
    end
  endtask

  task automatic set_codes(input logic [15:0] boot, input logic [15:0] reboot);
    cfg_valid <= 1'b1;
    cfg_index <= CfgBootIdx;
    cfg_data  <= boot;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_index <= CfgRebootIdx;
    cfg_data  <= reboot;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    directed_rows = '{
      // status completes at once; blank while idle is dropped; high byte is a bad command
      answer("S", ACT_STATUS, 1'b0, 16'd0, 8'd0, 16'd0),
      plain(8'h00),
      answer(8'hFF, ACT_BAD_CMD, 1'b0, 16'd0, 8'hFF, 16'd0),
      // ESC while waiting for the target aborts silently
      plain("L"), plain(ChEsc),
      // LED with target zero, blank before target, junk before value,
      // 65536 wraps to zero, second value after a colon, comma completes
      plain("l"), plain(ChSpace), plain("0"), plain("x"),
      plain("6"), plain("5"), plain("5"), plain("3"), plain("6"),
      plain(ChColon), plain("9"), plain(ChComma),
      // ESC while waiting for a value
      plain("r"), plain(ChEsc),
      // lowercase valve letter, then a bad target character
      plain("v"),
      answer("#", ACT_BAD_TARGET, 1'b0, 16'd0, "#", 16'd0),
      // valve target out of range
      plain("V"), plain("2"), plain("4"),
      answer(8'h0D, ACT_BAD_VALVE, 1'b0, 16'd0, 8'd0, 16'd2),
      // ESC inside a value
      plain("R"), plain("7"), plain(ChEsc),
      plain("V"), plain("1"), plain("0"),
      answer(8'h0A, ACT_VALVE, 1'b1, 16'd0, 8'd0, 16'd0),
      plain("r"), plain("5"), plain("5"), plain("1"), plain("1"),
      answer(8'h80, ACT_BOOTLOADER, 1'b0, BootCodeRst, 8'd0, 16'd0)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines against reset codes
    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].ch, directed_rows[i].has_want, directed_rows[i].want);
    end
    while (chars_sent < 140) send_random_command();

    // Code extremes: zero and all ones
    drain();
    set_codes(16'd0, 16'hFFFF);
    while (chars_sent < 240) send_random_command();

    // Hold the receiver off while status items keep coming, so the queue
    // fills and the input stalls
    hold_req = 1'b1;
    repeat (16) send_char(ChLowS & ~ChCaseBit, 1'b0, '0);

    // Both codes equal: bootloader must win
    drain();
    set_codes(16'hFFFF, 16'hFFFF);
    while (chars_sent < 320) send_random_command();

    // Random codes and full rate on both sides to the end
    drain();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_codes(16'($urandom), 16'($urandom));
    while (chars_sent < 400) send_random_command();

    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
